// File: hdl/pmp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and saturation helper for the particle motion predict unit.
// No dependencies.
package pmp_pkg;

   localparam int FIELD_W  = 24;
   localparam int COEF_W   = 18;
   localparam int NUM_REGS = 7;
   localparam int ADDR_W   = 5;
   localparam int DATA_W   = 32;
   localparam int IDX_W    = 3;
   localparam int PROD_W   = 43;
   localparam int SUM_W    = 44;
   localparam int WIDE_W   = 28;
   localparam int FRAC_W   = 16;

   localparam logic [1:0] MODEL_STAT  = 2'd0;
   localparam logic [1:0] MODEL_VEL   = 2'd1;
   localparam logic [1:0] MODEL_ACCEL = 2'd2;
   localparam logic [1:0] MODEL_NONE  = 2'd3;

   localparam logic [IDX_W-1:0] REG_STAT_DAMP  = 3'd0;
   localparam logic [IDX_W-1:0] REG_STAT_GAIN  = 3'd1;
   localparam logic [IDX_W-1:0] REG_VEL_DAMP   = 3'd2;
   localparam logic [IDX_W-1:0] REG_VEL_GAIN   = 3'd3;
   localparam logic [IDX_W-1:0] REG_ACCEL_DAMP = 3'd4;
   localparam logic [IDX_W-1:0] REG_ACCEL_GAIN = 3'd5;
   localparam logic [IDX_W-1:0] REG_TIME_STEP  = 3'd6;

   localparam logic [COEF_W-1:0] ONE_Q16  = 18'd65536;
   localparam logic [COEF_W-1:0] ZERO_Q16 = 18'd0;

   localparam logic signed [WIDE_W-1:0] SAT_HI = 28'sd8388607;
   localparam logic signed [WIDE_W-1:0] SAT_LO = -28'sd8388608;

   typedef struct packed {
      logic [1:0]                model_code;
      logic signed [FIELD_W-1:0] pos_x;
      logic signed [FIELD_W-1:0] pos_y;
      logic signed [FIELD_W-1:0] pos_z;
      logic signed [FIELD_W-1:0] vel_x;
      logic signed [FIELD_W-1:0] vel_y;
      logic signed [FIELD_W-1:0] vel_z;
      logic signed [FIELD_W-1:0] noise_x;
      logic signed [FIELD_W-1:0] noise_y;
      logic signed [FIELD_W-1:0] noise_z;
      logic                      last_particle;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] new_pos_x;
      logic signed [FIELD_W-1:0] new_pos_y;
      logic signed [FIELD_W-1:0] new_pos_z;
      logic signed [FIELD_W-1:0] new_vel_x;
      logic signed [FIELD_W-1:0] new_vel_y;
      logic signed [FIELD_W-1:0] new_vel_z;
      logic                      clipped;
      logic                      last_out;
   } rsp_type;

   typedef struct packed {
      logic [COEF_W-1:0] stat_damp;
      logic [COEF_W-1:0] stat_gain;
      logic [COEF_W-1:0] vel_damp;
      logic [COEF_W-1:0] vel_gain;
      logic [COEF_W-1:0] accel_damp;
      logic [COEF_W-1:0] accel_gain;
      logic [COEF_W-1:0] time_step;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      stat_damp:  ONE_Q16,
      stat_gain:  ZERO_Q16,
      vel_damp:   ONE_Q16,
      vel_gain:   ZERO_Q16,
      accel_damp: ONE_Q16,
      accel_gain: ZERO_Q16,
      time_step:  ZERO_Q16
   };

   // classified word: coefficients already picked by model code
   typedef struct packed {
      logic [COEF_W-1:0]         damp;
      logic [COEF_W-1:0]         gain;
      logic signed [FIELD_W-1:0] pos_x;
      logic signed [FIELD_W-1:0] pos_y;
      logic signed [FIELD_W-1:0] pos_z;
      logic signed [FIELD_W-1:0] vel_x;
      logic signed [FIELD_W-1:0] vel_y;
      logic signed [FIELD_W-1:0] vel_z;
      logic signed [FIELD_W-1:0] noise_x;
      logic signed [FIELD_W-1:0] noise_y;
      logic signed [FIELD_W-1:0] noise_z;
      logic                      last_particle;
   } work_type;

   // returns {clip, saturated Q8.16 value}
   function automatic logic [FIELD_W:0] sat_q24(input logic signed [WIDE_W-1:0] v);
      logic [FIELD_W:0] r;
      if (v > SAT_HI) begin
         r = {1'b1, SAT_HI[FIELD_W-1:0]};
      end else if (v < SAT_LO) begin
         r = {1'b1, SAT_LO[FIELD_W-1:0]};
      end else begin
         r = {1'b0, v[FIELD_W-1:0]};
      end
      return r;
   endfunction

endpackage

// File: hdl/pmp_fifo.sv
`timescale 1ns / 1ps
// Small register-based word queue with occupancy count.
// No package dependencies.
module pmp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic [WIDTH-1:0]               wr_data,
   input  logic                           pop,
   output logic [WIDTH-1:0]               rd_data,
   output logic                           full,
   output logic                           empty,
   output logic [$clog2(DEPTH+1)-1:0]     count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH+1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: hdl/pmp_csr.sv
`timescale 1ns / 1ps
// APB-style configuration registers: motion model coefficients and time step.
// Depends on pmp_pkg.
module pmp_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [pmp_pkg::ADDR_W-1:0]   paddr,
   input  logic [pmp_pkg::DATA_W-1:0]   pwdata,
   output logic [pmp_pkg::DATA_W-1:0]   prdata,
   output logic                         pready,
   output pmp_pkg::cfg_type             cfg
);

   pmp_pkg::cfg_type               cfg_ff, cfg_in;
   logic [pmp_pkg::IDX_W-1:0]      idx;
   logic [pmp_pkg::COEF_W-1:0]     wval;
   logic [pmp_pkg::COEF_W-1:0]     rval;
   logic                           wr_en;

   assign pready = 1'b1;
   assign cfg    = cfg_ff;
   assign idx    = paddr[pmp_pkg::ADDR_W-1:2];
   assign wval   = pwdata[pmp_pkg::COEF_W-1:0];
   assign wr_en  = psel && penable && pwrite && pready;
   assign prdata = {{(pmp_pkg::DATA_W-pmp_pkg::COEF_W){1'b0}}, rval};

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            pmp_pkg::REG_STAT_DAMP:  cfg_in.stat_damp  = wval;
            pmp_pkg::REG_STAT_GAIN:  cfg_in.stat_gain  = wval;
            pmp_pkg::REG_VEL_DAMP:   cfg_in.vel_damp   = wval;
            pmp_pkg::REG_VEL_GAIN:   cfg_in.vel_gain   = wval;
            pmp_pkg::REG_ACCEL_DAMP: cfg_in.accel_damp = wval;
            pmp_pkg::REG_ACCEL_GAIN: cfg_in.accel_gain = wval;
            pmp_pkg::REG_TIME_STEP:  cfg_in.time_step  = wval;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         pmp_pkg::REG_STAT_DAMP:  rval = cfg_ff.stat_damp;
         pmp_pkg::REG_STAT_GAIN:  rval = cfg_ff.stat_gain;
         pmp_pkg::REG_VEL_DAMP:   rval = cfg_ff.vel_damp;
         pmp_pkg::REG_VEL_GAIN:   rval = cfg_ff.vel_gain;
         pmp_pkg::REG_ACCEL_DAMP: rval = cfg_ff.accel_damp;
         pmp_pkg::REG_ACCEL_GAIN: rval = cfg_ff.accel_gain;
         pmp_pkg::REG_TIME_STEP:  rval = cfg_ff.time_step;
         default:                 rval = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= pmp_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: hdl/pmp_front.sv
`timescale 1ns / 1ps
// Front end: takes request words, picks damping and gain by model code, feeds the queue.
// Depends on pmp_pkg.
module pmp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  pmp_pkg::req_type    req_data,
   input  pmp_pkg::cfg_type    cfg,
   input  logic                mid_full,
   output logic                mid_push,
   output pmp_pkg::work_type   mid_data
);

   logic                       valid_ff, valid_in;
   pmp_pkg::work_type          work_ff, work_in;
   logic                       accept;
   logic [pmp_pkg::COEF_W-1:0] damp, gain;

   assign mid_push = valid_ff && !mid_full;
   assign full     = valid_ff && mid_full;
   assign accept   = push && !full;
   assign mid_data = work_ff;

   always_comb begin
      unique case (req_data.model_code)
         pmp_pkg::MODEL_STAT: begin
            damp = cfg.stat_damp;
            gain = cfg.stat_gain;
         end
         pmp_pkg::MODEL_VEL: begin
            damp = cfg.vel_damp;
            gain = cfg.vel_gain;
         end
         pmp_pkg::MODEL_ACCEL: begin
            damp = cfg.accel_damp;
            gain = cfg.accel_gain;
         end
         pmp_pkg::MODEL_NONE: begin
            damp = pmp_pkg::ONE_Q16;
            gain = pmp_pkg::ZERO_Q16;
         end
      endcase
   end

   always_comb begin
      work_in               = work_ff;
      work_in.damp          = damp;
      work_in.gain          = gain;
      work_in.pos_x         = req_data.pos_x;
      work_in.pos_y         = req_data.pos_y;
      work_in.pos_z         = req_data.pos_z;
      work_in.vel_x         = req_data.vel_x;
      work_in.vel_y         = req_data.vel_y;
      work_in.vel_z         = req_data.vel_z;
      work_in.noise_x       = req_data.noise_x;
      work_in.noise_y       = req_data.noise_y;
      work_in.noise_z       = req_data.noise_z;
      work_in.last_particle = req_data.last_particle;
      if (accept) begin
         valid_in = 1'b1;
      end else if (mid_push) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         work_ff <= work_in;
      end
   end

endmodule

// File: hdl/pmp_back.sv
`timescale 1ns / 1ps
// Back end: velocity and position update pipeline with a credited result queue.
// Depends on pmp_pkg and pmp_fifo.
module pmp_back #(
   parameter int OUT_DEPTH = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  pmp_pkg::work_type   mid_data,
   input  logic                mid_empty,
   output logic                mid_pop,
   input  logic [pmp_pkg::COEF_W-1:0] time_step,
   output logic                empty,
   input  logic                pop,
   output pmp_pkg::rsp_type    rsp_data
);

   localparam int FW    = pmp_pkg::FIELD_W;
   localparam int PW    = pmp_pkg::PROD_W;
   localparam int SW    = pmp_pkg::SUM_W;
   localparam int WW    = pmp_pkg::WIDE_W;
   localparam int CNT_W = $clog2(OUT_DEPTH+1);
   localparam logic [SW-1:0] HALF_S = SW'(32768);
   localparam logic [PW-1:0] HALF_P = PW'(32768);

   logic                 s1_v_ff, s1_v_in, s2_v_ff, s2_v_in, s3_v_ff, s3_v_in;
   logic signed [PW-1:0] s1_av_ff [3], s1_av_in [3];
   logic signed [PW-1:0] s1_bn_ff [3], s1_bn_in [3];
   logic signed [FW-1:0] s1_pos_ff [3], s1_pos_in [3];
   logic                 s1_last_ff, s1_last_in;
   logic signed [FW-1:0] s2_nv_ff [3], s2_nv_in [3];
   logic signed [FW-1:0] s2_pos_ff [3], s2_pos_in [3];
   logic                 s2_clip_ff, s2_clip_in, s2_last_ff, s2_last_in;
   logic signed [PW-1:0] s3_pd_ff [3], s3_pd_in [3];
   logic signed [FW-1:0] s3_nv_ff [3], s3_nv_in [3];
   logic signed [FW-1:0] s3_pos_ff [3], s3_pos_in [3];
   logic                 s3_clip_ff, s3_clip_in, s3_last_ff, s3_last_in;

   logic signed [FW-1:0] vel_a [3], noise_a [3], pos_a [3];
   logic [SW-1:0]        vsum [3];
   logic [FW:0]          vsat [3];
   logic [PW-1:0]        prnd [3];
   logic [WW-1:0]        psum [3];
   logic [FW:0]          psat [3];
   logic                 pclip;

   logic [CNT_W-1:0]     out_count;
   logic [CNT_W:0]       occ;
   logic                 out_full;
   pmp_pkg::rsp_type     out_word;

   assign occ = (CNT_W+1)'(s1_v_ff) + (CNT_W+1)'(s2_v_ff) + (CNT_W+1)'(s3_v_ff)
              + (CNT_W+1)'(out_count);
   assign mid_pop = !mid_empty && (occ < (CNT_W+1)'(OUT_DEPTH));

   always_comb begin
      vel_a   = '{mid_data.vel_x, mid_data.vel_y, mid_data.vel_z};
      noise_a = '{mid_data.noise_x, mid_data.noise_y, mid_data.noise_z};
      pos_a   = '{mid_data.pos_x, mid_data.pos_y, mid_data.pos_z};
      s1_v_in    = mid_pop;
      s1_last_in = mid_data.last_particle;
      s2_v_in    = s1_v_ff;
      s2_last_in = s1_last_ff;
      s3_v_in    = s2_v_ff;
      s3_last_in = s2_last_ff;
      s3_clip_in = s2_clip_ff;
      s2_clip_in = 1'b0;
      pclip      = s3_clip_ff;
      for (int i = 0; i < 3; i++) begin
         // a*v and b*n, Q2.16 x Q8.16
         s1_av_in[i]  = $signed({1'b0, mid_data.damp}) * vel_a[i];
         s1_bn_in[i]  = $signed({1'b0, mid_data.gain}) * noise_a[i];
         s1_pos_in[i] = pos_a[i];
         // round half up, floor shift, saturate
         vsum[i] = {s1_av_ff[i][PW-1], s1_av_ff[i]} + {s1_bn_ff[i][PW-1], s1_bn_ff[i]} + HALF_S;
         vsat[i] = pmp_pkg::sat_q24($signed(vsum[i][SW-1:pmp_pkg::FRAC_W]));
         s2_nv_in[i]  = vsat[i][FW-1:0];
         s2_pos_in[i] = s1_pos_ff[i];
         s2_clip_in   = s2_clip_in | vsat[i][FW];
         // dt*v'
         s3_pd_in[i]  = $signed({1'b0, time_step}) * s2_nv_ff[i];
         s3_nv_in[i]  = s2_nv_ff[i];
         s3_pos_in[i] = s2_pos_ff[i];
         prnd[i] = s3_pd_ff[i] + HALF_P;
         psum[i] = {prnd[i][PW-1], prnd[i][PW-1:pmp_pkg::FRAC_W]}
                 + {{(WW-FW){s3_pos_ff[i][FW-1]}}, s3_pos_ff[i]};
         psat[i] = pmp_pkg::sat_q24($signed(psum[i]));
         pclip   = pclip | psat[i][FW];
      end
      out_word.new_pos_x = psat[0][FW-1:0];
      out_word.new_pos_y = psat[1][FW-1:0];
      out_word.new_pos_z = psat[2][FW-1:0];
      out_word.new_vel_x = s3_nv_ff[0];
      out_word.new_vel_y = s3_nv_ff[1];
      out_word.new_vel_z = s3_nv_ff[2];
      out_word.clipped   = pclip;
      out_word.last_out  = s3_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
         s3_v_ff <= s3_v_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_av_ff   <= s1_av_in;
      s1_bn_ff   <= s1_bn_in;
      s1_pos_ff  <= s1_pos_in;
      s1_last_ff <= s1_last_in;
      s2_nv_ff   <= s2_nv_in;
      s2_pos_ff  <= s2_pos_in;
      s2_clip_ff <= s2_clip_in;
      s2_last_ff <= s2_last_in;
      s3_pd_ff   <= s3_pd_in;
      s3_nv_ff   <= s3_nv_in;
      s3_pos_ff  <= s3_pos_in;
      s3_clip_ff <= s3_clip_in;
      s3_last_ff <= s3_last_in;
   end

   pmp_fifo #(
      .WIDTH ($bits(pmp_pkg::rsp_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (s3_v_ff),
      .wr_data (out_word),
      .pop     (pop),
      .rd_data (rsp_data),
      .full    (out_full),
      .empty   (empty),
      .count   (out_count)
   );

   // credit check keeps the result queue from overflowing
   always_comb begin
      if (out_full && s3_v_ff) begin
         $error("pmp_back: result queue overflow");
      end
   end

endmodule

// File: hdl/particle_motion_predict_unit.sv
`timescale 1ns / 1ps
// Particle motion predict unit: one particle word in, one updated particle word out.
// Accepted words pass the front register, the middle queue write, three arithmetic stages
// and the result queue write before empty goes low; one word per cycle while nothing stalls.
// Reset (synchronous, active high) empties both queues and restores register defaults.
// Depends on pmp_pkg, pmp_csr, pmp_front, pmp_fifo, pmp_back.
module particle_motion_predict_unit #(
   parameter int MID_DEPTH = 4,
   parameter int OUT_DEPTH = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  pmp_pkg::req_type             req_data,
   output logic                         empty,
   input  logic                         pop,
   output pmp_pkg::rsp_type             rsp_data,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [pmp_pkg::ADDR_W-1:0]   paddr,
   input  logic [pmp_pkg::DATA_W-1:0]   pwdata,
   output logic [pmp_pkg::DATA_W-1:0]   prdata,
   output logic                         pready
);

   pmp_pkg::cfg_type                    cfg;
   pmp_pkg::work_type                   mid_wdata, mid_rdata;
   logic                                mid_push, mid_pop, mid_full, mid_empty;
   logic [$clog2(MID_DEPTH+1)-1:0]      mid_count;

   pmp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pmp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .cfg      (cfg),
      .mid_full (mid_full),
      .mid_push (mid_push),
      .mid_data (mid_wdata)
   );

   pmp_fifo #(
      .WIDTH ($bits(pmp_pkg::work_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (mid_push),
      .wr_data (mid_wdata),
      .pop     (mid_pop),
      .rd_data (mid_rdata),
      .full    (mid_full),
      .empty   (mid_empty),
      .count   (mid_count)
   );

   pmp_back #(
      .OUT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_data  (mid_rdata),
      .mid_empty (mid_empty),
      .mid_pop   (mid_pop),
      .time_step (cfg.time_step),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

   // front stalls only when the middle queue is full
   a_full_needs_mid_full: assert property (@(posedge clock) disable iff (reset)
      full |-> (mid_full && mid_count == ($clog2(MID_DEPTH+1))'(MID_DEPTH)))
      else $error("full without a full middle queue");

   a_empty_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> empty)
      else $error("result present right after reset");

   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && paddr[pmp_pkg::ADDR_W-1:2] < 3'(pmp_pkg::NUM_REGS))
      |=> (paddr != $past(paddr) ||
           prdata == {{(pmp_pkg::DATA_W-pmp_pkg::COEF_W){1'b0}},
                      $past(pwdata[pmp_pkg::COEF_W-1:0])}))
      else $error("register readback mismatch");

endmodule
